@@ sv/twnd_pkg.sv @@
`default_nettype none
package twnd_pkg;
   localparam int MaxGrid   = 16;
   localparam int FracBits  = 12;
   localparam int CellBits  = $clog2(MaxGrid);
   localparam int AddrBits  = 3 * CellBits;
   localparam int EntryBits = 3 * FracBits;
   localparam int DistBits  = 13;
   localparam int DeltaBits = FracBits + 2;       // signed, |d| < 2^(FracBits+1)
   localparam int SqBits    = 2 * FracBits + 4;   // sum of three squares
   localparam int RootBits  = SqBits / 2;
   localparam logic [DistBits-1:0] DistLimit = 13'd8191;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef struct packed {
      logic                start;
      logic [SqBits-1:0]   value;
   } sqrt_cmd_type;
endpackage
`default_nettype wire

@@ sv/twnd_ram.sv @@
`default_nettype none
module twnd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ sv/twnd_sqrt.sv @@
`default_nettype none
// Restoring integer square root, one result bit per cycle.
module twnd_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire twnd_pkg::sqrt_cmd_type        cmd,
   output logic                               done,
   output logic [twnd_pkg::RootBits-1:0]      root
);
   import twnd_pkg::*;

   localparam int StepBits = $clog2(RootBits + 1);

   logic [SqBits-1:0]   rem_ff, rem_in;
   logic [SqBits-1:0]   val_ff, val_in;
   logic [RootBits-1:0] root_ff, root_in;
   logic [StepBits-1:0] step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SqBits-1:0]   trial;
   logic [SqBits-1:0]   shifted;

   always_comb begin
      rem_in  = rem_ff;
      val_in  = val_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[SqBits-3:0], val_ff[SqBits-1 -: 2]};
      trial   = SqBits'({root_ff, 2'b01});
      if (cmd.start) begin
         rem_in  = '0;
         val_in  = cmd.value;
         root_in = '0;
         step_in = StepBits'(RootBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[SqBits-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[RootBits-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[RootBits-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      val_ff  <= val_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff) else $error("sqrt restarted while busy");
   a_done_len: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without work");
   a_step_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> step_ff == '0 || $past(cmd.start) == 1'b0)
      else $error("step count off");
`endif
endmodule
`default_nettype wire

@@ sv/tiled_worley_nearest_distance_unit.sv @@
`default_nettype none
// Tiled Worley F1 unit. A load, clear or ignored word keeps busy high for one
// cycle after the accepting edge. A query passes a setup state, then reads the
// 27 neighboring feature points from the feature memory, one per cycle, then
// runs a 14-step bit-serial square root on the smallest squared distance;
// rsp_valid strobes in the send state that follows, and busy drops in the
// cycle after that, so busy stays high for the whole query. The receiver
// cannot stall: rsp_valid is high for that one cycle only. Unloaded cells
// read garbage.
module tiled_worley_nearest_distance_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [3:0]  req_cell_x,
   input  wire logic [3:0]  req_cell_y,
   input  wire logic [3:0]  req_cell_z,
   input  wire logic [11:0] req_frac_x,
   input  wire logic [11:0] req_frac_y,
   input  wire logic [11:0] req_frac_z,
   output logic             rsp_valid,
   output logic [12:0]      rsp_near_distance,
   output logic [3:0]       rsp_near_cell_x,
   output logic [3:0]       rsp_near_cell_y,
   output logic [3:0]       rsp_near_cell_z,
   output logic [12:0]      rsp_running_max,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_data
);
   import twnd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_SCAN, S_ROOT, S_SEND
   } state_type;

   state_type            state_ff, state_in;
   logic [4:0]           grid_ff, grid_in;
   logic [DistBits-1:0]  max_ff, max_in;
   logic [CellBits-1:0]  cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic [FracBits-1:0]  fx_ff, fy_ff, fz_ff;
   logic [1:0]           i_ff, j_ff, k_ff, i_in, j_in, k_in;
   logic [CellBits-1:0]  nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic [1:0]           pi_ff, pj_ff, pk_ff;
   logic [CellBits-1:0]  px_ff, py_ff, pz_ff;
   logic                 pv_ff, pv_in;
   logic                 issue;
   logic                 last_ff, last_in;
   logic [SqBits-1:0]    best_ff, best_in;
   logic                 bval_ff, bval_in;
   logic [CellBits-1:0]  bx_ff, by_ff, bz_ff, bx_in, by_in, bz_in;
   logic [DistBits-1:0]  dist_ff, dist_in;
   logic [CellBits-1:0]  ox_ff, oy_ff, oz_ff;
   logic                 ovalid_ff, ovalid_in;

   logic [4:0]           n_eff;
   logic [CellBits-1:0]  nm1;
   logic                 wr_en;
   logic [AddrBits-1:0]  wr_addr, rd_addr;
   logic [EntryBits-1:0] wr_data, rd_data;
   logic [DeltaBits-1:0] dx, dy, dz;
   logic [SqBits-1:0]    sq;
   logic                 root_done;
   logic [RootBits-1:0]  root;
   sqrt_cmd_type         sq_cmd;

   assign n_eff = (grid_ff == 5'd0) ? 5'd1 :
                  (grid_ff > 5'(MaxGrid)) ? 5'(MaxGrid) : grid_ff;
   assign nm1   = CellBits'(n_eff - 5'd1);

   function automatic logic [CellBits-1:0] cell_mod(
      input logic [CellBits-1:0] c, input logic [4:0] n);
      logic [7:0] v;
      logic [7:0] d;
      begin
         v = {4'b0000, c};
         // restoring remainder: the quotient fits in four bits
         for (int s = 3; s >= 0; s--) begin
            d = {3'b000, n} << s;
            if (v >= d) v = v - d;
         end
         cell_mod = CellBits'(v);
      end
   endfunction

   // Step a wrapped coordinate by +1.
   function automatic logic [CellBits-1:0] wrap_inc(
      input logic [CellBits-1:0] c, input logic [CellBits-1:0] top);
      wrap_inc = (c == top) ? '0 : c + 1'b1;
   endfunction
   function automatic logic [CellBits-1:0] wrap_dec(
      input logic [CellBits-1:0] c, input logic [CellBits-1:0] top);
      wrap_dec = (c == '0) ? top : c - 1'b1;
   endfunction

   function automatic logic [DeltaBits-1:0] axis_delta(
      input logic [1:0] off, input logic [FracBits-1:0] f,
      input logic [FracBits-1:0] s);
      logic [DeltaBits-1:0] base;
      begin
         base = (off == 2'd0) ? -DeltaBits'(1 << FracBits) :
                (off == 2'd1) ? '0 : DeltaBits'(1 << FracBits);
         axis_delta = base + DeltaBits'(f) - DeltaBits'(s);
      end
   endfunction

   function automatic logic [SqBits-1:0] sq_of(input logic [DeltaBits-1:0] d);
      logic [DeltaBits-1:0] m;
      logic [SqBits-1:0]    a;
      begin
         m = d[DeltaBits-1] ? -d : d;
         a = SqBits'(m);
         sq_of = a * a;
      end
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;

   // Memory ports
   assign wr_en   = start && !busy && (req_type == REQ_LOAD);
   assign wr_addr = {cell_mod(req_cell_x, n_eff), cell_mod(req_cell_y, n_eff),
                     cell_mod(req_cell_z, n_eff)};
   assign wr_data = {req_frac_x, req_frac_y, req_frac_z};
   assign rd_addr = {nx_ff, ny_ff, nz_ff};
   assign issue   = (state_ff == S_SCAN) && !last_ff;

   twnd_ram #(.Width(EntryBits), .Depth(MaxGrid ** 3)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign dx = axis_delta(pi_ff, rd_data[3*FracBits-1 -: FracBits], fx_ff);
   assign dy = axis_delta(pj_ff, rd_data[2*FracBits-1 -: FracBits], fy_ff);
   assign dz = axis_delta(pk_ff, rd_data[FracBits-1:0], fz_ff);
   assign sq = sq_of(dx) + sq_of(dy) + sq_of(dz);

   assign sq_cmd.start = (state_ff == S_SCAN) && last_ff && !pv_ff;
   assign sq_cmd.value = best_ff;

   twnd_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (sq_cmd),
      .done  (root_done),
      .root  (root)
   );

   always_comb begin
      state_in  = state_ff;
      grid_in   = grid_ff;
      max_in    = max_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff;
      pv_in     = issue;
      last_in   = last_ff;
      best_in   = best_ff;
      bval_in   = bval_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      dist_in   = dist_ff;
      ovalid_in = 1'b0;
      if (csr_valid && csr_ready) begin
         grid_in = csr_data;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cx_in = cell_mod(req_cell_x, n_eff);
               cy_in = cell_mod(req_cell_y, n_eff);
               cz_in = cell_mod(req_cell_z, n_eff);
               case (req_type)
                  REQ_QUERY: state_in = S_PREP;
                  REQ_CLEAR: begin
                     max_in   = '0;
                     state_in = S_SEND;
                  end
                  default:   state_in = S_SEND;
               endcase
            end
         end
         S_PREP: begin
            i_in = 2'd0; j_in = 2'd0; k_in = 2'd0;
            nx_in = wrap_dec(cx_ff, nm1);
            ny_in = wrap_dec(cy_ff, nm1);
            nz_in = wrap_dec(cz_ff, nm1);
            last_in = 1'b0;
            bval_in = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (issue) begin
               if (k_ff != 2'd2) begin
                  k_in  = k_ff + 1'b1;
                  nz_in = wrap_inc(nz_ff, nm1);
               end else begin
                  k_in  = 2'd0;
                  nz_in = wrap_dec(cz_ff, nm1);
                  if (j_ff != 2'd2) begin
                     j_in  = j_ff + 1'b1;
                     ny_in = wrap_inc(ny_ff, nm1);
                  end else begin
                     j_in  = 2'd0;
                     ny_in = wrap_dec(cy_ff, nm1);
                     if (i_ff != 2'd2) begin
                        i_in  = i_ff + 1'b1;
                        nx_in = wrap_inc(nx_ff, nm1);
                     end else begin
                        last_in = 1'b1;
                     end
                  end
               end
            end
            if (pv_ff && (!bval_ff || sq < best_ff)) begin
               best_in = sq;
               bval_in = 1'b1;
               bx_in = px_ff; by_in = py_ff; bz_in = pz_ff;
            end
            if (last_ff && !pv_ff) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (root_done) begin
               dist_in = (root > RootBits'(DistLimit)) ? DistLimit
                                                        : DistBits'(root);
               if (dist_in > max_ff) begin
                  max_in = dist_in;
               end
               ovalid_in = 1'b1;
               state_in  = S_SEND;
            end
         end
         S_SEND:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         grid_ff   <= 5'd4;
         max_ff    <= '0;
         pv_ff     <= 1'b0;
         last_ff   <= 1'b0;
         bval_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         grid_ff   <= grid_in;
         max_ff    <= max_in;
         pv_ff     <= pv_in;
         last_ff   <= last_in;
         bval_ff   <= bval_in;
         ovalid_ff <= ovalid_in;
      end
      if (start && !busy) begin
         fx_ff <= req_frac_x;
         fy_ff <= req_frac_y;
         fz_ff <= req_frac_z;
      end
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in;
      pi_ff <= i_ff; pj_ff <= j_ff; pk_ff <= k_ff;
      px_ff <= nx_ff; py_ff <= ny_ff; pz_ff <= nz_ff;
      best_ff <= best_in;
      bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in;
      dist_ff <= dist_in;
      ox_ff <= bx_ff; oy_ff <= by_ff; oz_ff <= bz_ff;
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_near_distance = dist_ff;
   assign rsp_near_cell_x   = ox_ff;
   assign rsp_near_cell_y   = oy_ff;
   assign rsp_near_cell_z   = oz_ff;
   assign rsp_running_max   = max_ff;

`ifndef SYNTH
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_SEND) else $error("response outside send");
   a_max_ge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_running_max >= rsp_near_distance)
      else $error("running max below distance");
   a_no_wr_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy) else $error("memory write while busy");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> state_ff == S_IDLE) else $error("csr ready while busy");
`endif
endmodule
`default_nettype wire
